// File: rtl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, codes and item types of the size class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int ALIGN       = 64;
    localparam int LOG2_ALIGN  = $clog2(ALIGN);
    localparam int NUM_CLASSES = 16;
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_BITS   = 32;

    localparam int SIZE_W      = 22;
    localparam int ADDR_W      = 32;
    localparam int STAT_W      = 32;
    localparam int CHUNK_W     = 25;
    localparam int CHUNK_RESET = 1048576;

    // class size never exceeds twice the largest rounded request
    localparam int CLS_BYTES_W = SIZE_W + 2;
    // width of the size in alignment units, rounded up
    localparam int Q_W         = SIZE_W + 1 - LOG2_ALIGN;
    localparam int KRAW_W      = $clog2(SIZE_W + 2);

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_EXHAUSTED  = 3'd3,
        ST_STACK_FULL = 3'd4
    } status_t;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        status_t           status;
        logic              from_free_list;
        logic [STAT_W-1:0] live_bytes;
        logic [STAT_W-1:0] peak_live_bytes;
        logic [STAT_W-1:0] arena_bytes;
        logic [STAT_W-1:0] hit_count;
        logic [STAT_W-1:0] miss_count;
    } rsp_t;

endpackage

// File: rtl/scpa_req_if.sv
// ----------------------------------------------------------------------------
// scpa_req_if
// Request channel: valid/ready handshake carrying one allocate or free item.
// ----------------------------------------------------------------------------
interface scpa_req_if;

    logic            valid;
    logic            ready;
    scpa_pkg::req_t  payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: rtl/scpa_rsp_if.sv
// ----------------------------------------------------------------------------
// scpa_rsp_if
// Result channel: valid/ready handshake carrying one allocator result item.
// ----------------------------------------------------------------------------
interface scpa_rsp_if;

    logic            valid;
    logic            ready;
    scpa_pkg::rsp_t  payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: rtl/scpa_class_decode.sv
// ----------------------------------------------------------------------------
// scpa_class_decode
// Rounds a byte size up to the alignment and then to a power-of-two class.
// ----------------------------------------------------------------------------
module scpa_class_decode #(
    parameter int  NUM_CLASSES = scpa_pkg::NUM_CLASSES,
    localparam int CLS_W       = $clog2(NUM_CLASSES)
) (
    input  logic [scpa_pkg::SIZE_W-1:0]      size_bytes,
    output logic [CLS_W-1:0]                 cls_idx,
    output logic [scpa_pkg::CLS_BYTES_W-1:0] cls_bytes,
    output logic                             too_large
);

    logic [scpa_pkg::SIZE_W:0]   padded;
    logic [scpa_pkg::Q_W-1:0]    quot;
    logic [scpa_pkg::Q_W-1:0]    quot_m1;
    logic [scpa_pkg::KRAW_W-1:0] k_raw;

    always_comb
    begin
        padded  = {1'b0, size_bytes} + (scpa_pkg::SIZE_W + 1)'(scpa_pkg::ALIGN - 1);
        quot    = padded[scpa_pkg::SIZE_W:scpa_pkg::LOG2_ALIGN];
        quot_m1 = quot - scpa_pkg::Q_W'(1);
        // class index is the bit length of units minus one
        k_raw   = '0;
        for (int i = 0; i < scpa_pkg::Q_W; i++)
        begin
            if (quot_m1[i])
            begin
                k_raw = scpa_pkg::KRAW_W'(i + 1);
            end
        end
        too_large = k_raw >= scpa_pkg::KRAW_W'(NUM_CLASSES);
        cls_idx   = k_raw[CLS_W-1:0];
        cls_bytes = scpa_pkg::CLS_BYTES_W'(scpa_pkg::ALIGN) << k_raw;
    end

endmodule

// File: rtl/scpa_stack_mem.sv
// ----------------------------------------------------------------------------
// scpa_stack_mem
// Free block storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scpa_stack_mem #(
    parameter int  DEPTH = scpa_pkg::NUM_CLASSES * scpa_pkg::STACK_DEPTH,
    parameter int  WIDTH = scpa_pkg::ADDR_W,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] stack_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/size_class_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator_unit
// Segregated power-of-two free list allocator with bump pointer arena.
//
//   channel  direction  handshake      content
//   req      in         valid/ready    operation, size_bytes, block_address
//   rsp      out        valid/ready    address, status, reuse flag, statistics
//   cfg      in         cfg_wr_en      chunk_bytes
//
// Each item is worked in two steps: class decode and stack read in the accept
// cycle, then update and result register. One item is in work at a
// time; the next is accepted while a finished result waits on rsp.
// A stalled rsp holds the item in work until the result register frees.
// Reset clears fill counts and statistics at once; the stack memory is not
// cleared, entries above a fill count are never used.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_unit #(
    parameter int NUM_CLASSES = scpa_pkg::NUM_CLASSES,
    parameter int STACK_DEPTH = scpa_pkg::STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [scpa_pkg::CHUNK_W-1:0]  cfg_wr_data,
    scpa_req_if.sink                      req,
    scpa_rsp_if.source                    rsp
);

    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int CUR_W     = scpa_pkg::ADDR_BITS + 1;
    localparam int LIM_W     = scpa_pkg::ADDR_BITS + 2;
    localparam int STAT_W    = scpa_pkg::STAT_W;
    localparam int CHUNK_W   = scpa_pkg::CHUNK_W;
    localparam int CB_W      = scpa_pkg::CLS_BYTES_W;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(1) << scpa_pkg::ADDR_BITS;

    // decode and stack read
    logic [CLS_W-1:0]        dec_k;
    logic [CB_W-1:0]         dec_cls;
    logic                    dec_too_large;
    logic [FILL_W-1:0]       rd_fill;
    logic [MEM_AW-1:0]       rd_addr;
    logic [scpa_pkg::ADDR_W-1:0] rd_data;
    logic                    accept;
    logic                    done;

    // item in work
    logic                    busy_reg;
    scpa_pkg::req_t          req_reg;
    logic [CLS_W-1:0]        k_reg;
    logic [CB_W-1:0]         cls_reg;
    logic                    too_large_reg;

    // allocator state
    logic [CHUNK_W-1:0]      chunk_bytes_reg;
    logic [FILL_W-1:0]       fill_reg [NUM_CLASSES];
    logic [CUR_W-1:0]        cursor_reg;
    logic [CUR_W-1:0]        cursor_next;
    logic [CHUNK_W-1:0]      left_reg;
    logic [CHUNK_W-1:0]      left_next;
    logic [CUR_W-1:0]        end_reg;
    logic [CUR_W-1:0]        end_next;
    logic [STAT_W-1:0]       arena_reg;
    logic [STAT_W-1:0]       arena_next;
    logic [STAT_W-1:0]       live_reg;
    logic [STAT_W-1:0]       live_next;
    logic [STAT_W-1:0]       peak_reg;
    logic [STAT_W-1:0]       peak_next;
    logic [STAT_W-1:0]       hits_reg;
    logic [STAT_W-1:0]       hits_next;
    logic [STAT_W-1:0]       misses_reg;
    logic [STAT_W-1:0]       misses_next;

    // result
    logic                    rsp_valid_reg;
    scpa_pkg::rsp_t          rsp_reg;
    scpa_pkg::rsp_t          rsp_next;

    // update datapath
    logic [FILL_W-1:0]       fill_k;
    logic                    fill_we;
    logic [FILL_W-1:0]       fill_wval;
    logic                    need_new;
    logic [CHUNK_W-1:0]      csize;
    logic [LIM_W-1:0]        chunk_top;
    logic                    exhausted;
    logic [CUR_W-1:0]        base;
    logic [STAT_W:0]         live_sum;
    logic [STAT_W-1:0]       live_up;
    logic [STAT_W-1:0]       live_down;
    logic [STAT_W:0]         arena_sum;
    logic [STAT_W-1:0]       arena_up;
    logic [STAT_W-1:0]       hits_up;
    logic [STAT_W-1:0]       misses_up;
    logic                    mem_wr_en;
    logic [MEM_AW-1:0]       wr_addr;
    scpa_pkg::status_t       status;
    logic [scpa_pkg::ADDR_W-1:0] addr_out;
    logic                    reused;

    assign accept    = req.valid && req.ready;
    assign done      = busy_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !busy_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    scpa_class_decode #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_decode (
        .size_bytes (req.payload.size_bytes),
        .cls_idx    (dec_k),
        .cls_bytes  (dec_cls),
        .too_large  (dec_too_large)
    );

    // top of stack for the decoded class, push slot for the class in work
    assign rd_fill = fill_reg[dec_k];
    assign rd_addr = MEM_AW'(dec_k) * MEM_AW'(STACK_DEPTH) + MEM_AW'(rd_fill - FILL_W'(1));
    assign wr_addr = MEM_AW'(k_reg) * MEM_AW'(STACK_DEPTH) + MEM_AW'(fill_k);

    scpa_stack_mem #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (scpa_pkg::ADDR_W)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (req_reg.block_address),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // arithmetic shared by the update paths
    always_comb
    begin
        fill_k    = fill_reg[k_reg];
        need_new  = CHUNK_W'(cls_reg) > left_reg;
        csize     = (chunk_bytes_reg > CHUNK_W'(cls_reg)) ? chunk_bytes_reg : CHUNK_W'(cls_reg);
        chunk_top = {1'b0, end_reg} + LIM_W'(csize);
        exhausted = chunk_top > LIMIT;
        base      = need_new ? end_reg : cursor_reg;
        live_sum  = {1'b0, live_reg} + (STAT_W + 1)'(cls_reg);
        live_up   = live_sum[STAT_W] ? '1 : live_sum[STAT_W-1:0];
        live_down = (live_reg > STAT_W'(cls_reg)) ? live_reg - STAT_W'(cls_reg) : '0;
        arena_sum = {1'b0, arena_reg} + (STAT_W + 1)'(csize);
        arena_up  = arena_sum[STAT_W] ? '1 : arena_sum[STAT_W-1:0];
        hits_up   = (&hits_reg) ? hits_reg : hits_reg + STAT_W'(1);
        misses_up = (&misses_reg) ? misses_reg : misses_reg + STAT_W'(1);
    end

    // request update
    always_comb
    begin
        cursor_next = cursor_reg;
        left_next   = left_reg;
        end_next    = end_reg;
        arena_next  = arena_reg;
        live_next   = live_reg;
        peak_next   = peak_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        fill_we     = 1'b0;
        fill_wval   = fill_k;
        mem_wr_en   = 1'b0;
        status      = scpa_pkg::ST_OK;
        addr_out    = '0;
        reused      = 1'b0;

        if (req_reg.size_bytes == '0
            || (req_reg.operation == scpa_pkg::OP_FREE && req_reg.block_address == '0))
        begin
            status = scpa_pkg::ST_IGNORED;
        end
        else if (too_large_reg)
        begin
            status = scpa_pkg::ST_TOO_LARGE;
        end
        else if (req_reg.operation == scpa_pkg::OP_ALLOC)
        begin
            if (fill_k != '0)
            begin
                // hit: pop newest freed block
                fill_we   = 1'b1;
                fill_wval = fill_k - FILL_W'(1);
                addr_out  = rd_data;
                reused    = 1'b1;
                hits_next = hits_up;
                live_next = live_up;
            end
            else if (need_new && exhausted)
            begin
                status = scpa_pkg::ST_EXHAUSTED;
            end
            else
            begin
                // miss: bump from current or new chunk
                addr_out    = base[scpa_pkg::ADDR_W-1:0];
                cursor_next = base + CUR_W'(cls_reg);
                left_next   = (need_new ? csize : left_reg) - CHUNK_W'(cls_reg);
                end_next    = need_new ? chunk_top[CUR_W-1:0] : end_reg;
                arena_next  = need_new ? arena_up : arena_reg;
                misses_next = misses_up;
                live_next   = live_up;
            end
            peak_next = (live_next > peak_reg) ? live_next : peak_reg;
        end
        else
        begin
            if (fill_k >= FILL_W'(STACK_DEPTH))
            begin
                status = scpa_pkg::ST_STACK_FULL;
            end
            else
            begin
                // push freed block
                mem_wr_en = done;
                fill_we   = 1'b1;
                fill_wval = fill_k + FILL_W'(1);
                live_next = live_down;
            end
        end

        rsp_next.address         = addr_out;
        rsp_next.status          = status;
        rsp_next.from_free_list  = reused;
        rsp_next.live_bytes      = live_next;
        rsp_next.peak_live_bytes = peak_next;
        rsp_next.arena_bytes     = arena_next;
        rsp_next.hit_count       = hits_next;
        rsp_next.miss_count      = misses_next;
    end

    // control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            chunk_bytes_reg <= CHUNK_W'(scpa_pkg::CHUNK_RESET);
            cursor_reg      <= CUR_W'(scpa_pkg::ALIGN);
            left_reg        <= '0;
            end_reg         <= CUR_W'(scpa_pkg::ALIGN);
            arena_reg       <= '0;
            live_reg        <= '0;
            peak_reg        <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                chunk_bytes_reg <= cfg_wr_data;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (done)
            begin
                cursor_reg <= cursor_next;
                left_reg   <= left_next;
                end_reg    <= end_next;
                arena_reg  <= arena_next;
                live_reg   <= live_next;
                peak_reg   <= peak_next;
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                if (fill_we)
                begin
                    fill_reg[k_reg] <= fill_wval;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req.payload;
            k_reg         <= dec_k;
            cls_reg       <= dec_cls;
            too_large_reg <= dec_too_large;
        end
        if (done)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: rtl/scpa_checker.sv
// ----------------------------------------------------------------------------
// scpa_checker
// Port level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module scpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input scpa_pkg::rsp_t rsp_payload
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("stalled result item changed");

    // only a successful allocation gives an address
    a_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status != scpa_pkg::ST_OK
        |-> rsp_payload.address == '0 && !rsp_payload.from_free_list)
        else $error("address or reuse flag on a failed item");

    // reuse only on success
    a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.from_free_list |-> rsp_payload.status == scpa_pkg::ST_OK)
        else $error("reuse flag with bad status");

    // peak never below live
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_payload.peak_live_bytes >= rsp_payload.live_bytes)
        else $error("peak below live bytes");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while another is in work");

endmodule

bind size_class_pool_allocator_unit scpa_checker u_scpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
